@@ hdl/crc16_frame_receiver_top_macros.svh @@
// Assertion macros used by the port-level checker of the CRC-16 frame receiver.
// Both macros expect a signal named clk, and CRCFRX_ASSERT also arst_n, in the scope where it is used.
`ifndef CRC16_FRAME_RECEIVER_TOP_MACROS_SVH
`define CRC16_FRAME_RECEIVER_TOP_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define CRCFRX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define CRCFRX_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/crcfrx_pkg.sv @@
// Package for the CRC-16 frame receiver: result type, widths and the bytewise CRC step.
// No dependencies.
`default_nettype none

package crcfrx_pkg;

	localparam int BufferSizeDefault = 256;
	localparam int MinFrameBytes     = 10;
	localparam logic [15:0] CrcPoly  = 16'h1021;
	localparam int InDataW           = 8;
	localparam int OutDataW          = 72;

	typedef struct packed {
		logic [7:0]  byte_index;
		logic        frame_found;
		logic [8:0]  frame_length;
		logic [15:0] dest_addr;
		logic [15:0] source_addr;
		logic [7:0]  payload_length;
		logic [7:0]  operation;
	} res_t;

	// CRC-16, MSB first, one byte folded in through eight shift steps.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			crc = crc[15] ? ({crc[14:0], 1'b0} ^ CrcPoly) : {crc[14:0], 1'b0};
		end
		return crc;
	endfunction

endpackage

`default_nettype wire

@@ hdl/crcfrx_in_reg.sv @@
// Input register of the CRC-16 frame receiver: holds one accepted byte until it can advance.
// Depends on crcfrx_pkg.
`default_nettype none

module crcfrx_in_reg import crcfrx_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [InDataW-1:0] s_tdata,
	input  wire logic               out_free,
	output logic                    adv,
	output logic [7:0]              byte_s1
);

	logic valid_s1;

	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[7:0];
		end
	end

endmodule

`default_nettype wire

@@ hdl/crcfrx_core.sv @@
// Frame state of the CRC-16 frame receiver: running CRC, count, header capture and detection.
// Depends on crcfrx_pkg.
`default_nettype none

module crcfrx_core import crcfrx_pkg::*; #(
	parameter int BUFFER_SIZE = BufferSizeDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic [7:0] byte_s1,
	output res_t            res
);

	localparam int CntW = $clog2(BUFFER_SIZE + 1);

	logic [15:0]     crc_q, crc_b, crc_n;
	logic [CntW-1:0] cnt_q, pos, cnt_n;
	logic            nz_q, nz_b, nz_n;
	logic [15:0]     dest_q, dest_b, dest_n;
	logic [15:0]     src_q, src_b, src_n;
	logic [7:0]      len_q, len_b, len_n;
	logic [7:0]      op_q, op_b, op_n;
	logic            ovf, found;
	logic [31:0]     pos_ext, cnt_ext;

	// A full buffer starts over before the byte is taken.
	assign ovf = cnt_q >= CntW'(BUFFER_SIZE);

	always_comb begin
		crc_b  = ovf ? 16'h0000 : crc_q;
		pos    = ovf ? '0 : cnt_q;
		nz_b   = ovf ? 1'b0 : nz_q;
		dest_b = ovf ? 16'h0000 : dest_q;
		src_b  = ovf ? 16'h0000 : src_q;
		len_b  = ovf ? 8'h00 : len_q;
		op_b   = ovf ? 8'h00 : op_q;

		crc_n  = crc16_byte(crc_b, byte_s1);
		nz_n   = nz_b || (byte_s1 != 8'h00);
		cnt_n  = pos + CntW'(1);
		dest_n = dest_b;
		src_n  = src_b;
		len_n  = len_b;
		op_n   = op_b;

		case (pos)
			CntW'(0): dest_n = {byte_s1, dest_b[7:0]};
			CntW'(1): dest_n = {dest_b[15:8], byte_s1};
			CntW'(2): src_n  = {byte_s1, src_b[7:0]};
			CntW'(3): src_n  = {src_b[15:8], byte_s1};
			CntW'(4): len_n  = byte_s1;
			CntW'(7): op_n   = byte_s1;
			default: ;
		endcase

		found   = (cnt_n >= CntW'(MinFrameBytes)) && nz_n && (crc_n == 16'h0000);
		pos_ext = 32'(pos);
		cnt_ext = 32'(cnt_n);

		res.byte_index     = pos_ext[7:0];
		res.frame_found    = found;
		res.frame_length   = found ? cnt_ext[8:0] : 9'd0;
		res.dest_addr      = found ? dest_n : 16'h0000;
		res.source_addr    = found ? src_n : 16'h0000;
		res.payload_length = found ? len_n : 8'h00;
		res.operation      = found ? op_n : 8'h00;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= 16'h0000;
			cnt_q  <= '0;
			nz_q   <= 1'b0;
			dest_q <= 16'h0000;
			src_q  <= 16'h0000;
			len_q  <= 8'h00;
			op_q   <= 8'h00;
		end else if (adv) begin
			if (found) begin
				crc_q  <= 16'h0000;
				cnt_q  <= '0;
				nz_q   <= 1'b0;
				dest_q <= 16'h0000;
				src_q  <= 16'h0000;
				len_q  <= 8'h00;
				op_q   <= 8'h00;
			end else begin
				crc_q  <= crc_n;
				cnt_q  <= cnt_n;
				nz_q   <= nz_n;
				dest_q <= dest_n;
				src_q  <= src_n;
				len_q  <= len_n;
				op_q   <= op_n;
			end
		end
	end

endmodule

`default_nettype wire

@@ hdl/crcfrx_out_reg.sv @@
// Result register of the CRC-16 frame receiver: holds one result beat and packs it for the bus.
// Depends on crcfrx_pkg.
`default_nettype none

module crcfrx_out_reg import crcfrx_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  res_t                     res,
	output logic                     out_free,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [OutDataW-1:0]      m_tdata,
	output logic                     m_tuser
);

	res_t res_q;
	logic valid_q;

	assign out_free = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.frame_found;
	assign m_tdata  = {7'b0, res_q.operation, res_q.payload_length, res_q.source_addr,
		res_q.dest_addr, res_q.frame_length, res_q.byte_index};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ hdl/crc16_frame_receiver_top.sv @@
// Top level of the CRC-16 frame receiver: input register, frame state and result register.
// Depends on crcfrx_pkg, crcfrx_in_reg, crcfrx_core and crcfrx_out_reg.
//
//   Channel   Direction  Beat contents
//   s_*       in         s_tdata[7:0] = rx_byte
//   m_*       out        m_tdata = byte_index, frame_length, dest_addr, source_addr,
//                        payload_length, operation; m_tuser = frame_found
//
// The block takes one beat per clock cycle while s_tready is high and returns exactly one
// result beat for each. A byte is held in the input register until the result register is
// free; the CRC update, header capture and frame test are combinational and registered
// into the result register; m_tvalid rises in the cycle after the byte moves on.
// The asynchronous reset clears the frame state and both valid flags; no clearing pass is needed.
// The input register and result register form two slots, so a byte is still accepted while a
// result waits on m_tready; input stalls only when both slots are full.
`default_nettype none

module crc16_frame_receiver_top import crcfrx_pkg::*; #(
	// Buffer depth in bytes; the count starts over on the byte after this many have been taken.
	parameter int BUFFER_SIZE = BufferSizeDefault
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// Bits from the lowest up: rx_byte[7:0].
	input  wire logic [InDataW-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// Bits from the lowest up: byte_index[7:0], frame_length[16:8], dest_addr[32:17],
	// source_addr[48:33], payload_length[56:49], operation[64:57], zero fill [71:65].
	output logic [OutDataW-1:0]      m_tdata,
	// Bits from the lowest up: frame_found[0].
	output logic                     m_tuser
);

	logic       out_free;
	logic       adv;
	logic [7:0] byte_s1;
	res_t       res;

	// Input slot; a byte moves on whenever the result slot is empty or being drained.
	crcfrx_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.out_free (out_free),
		.adv      (adv),
		.byte_s1  (byte_s1)
	);

	// Running CRC, count and header capture; the state advances once per byte that moves on.
	crcfrx_core #(
		.BUFFER_SIZE (BUFFER_SIZE)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	// Result slot driving the master side of the stream.
	crcfrx_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

@@ hdl/crcfrx_checker.sv @@
// Port-level checker for the CRC-16 frame receiver, bound to the top level.
// Depends on crcfrx_pkg and crc16_frame_receiver_top_macros.svh.
`default_nettype none
`include "crc16_frame_receiver_top_macros.svh"

module crcfrx_checker import crcfrx_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OutDataW-1:0] m_tdata,
	input wire logic                m_tuser
);

	// After an edge with reset held, no result beat is offered at the next edge.
	`CRCFRX_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |=> !m_tvalid, "result beat during reset")

	// A stalled result beat holds its contents.
	`CRCFRX_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

	// With an empty result slot the input side never stalls.
	`CRCFRX_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

	// A beat without a frame carries zero header and length fields.
	`CRCFRX_ASSERT(a_idle_fields_zero, m_tvalid && !m_tuser |-> m_tdata[OutDataW-1:8] == '0, "nonzero header without frame")

endmodule

bind crc16_frame_receiver_top crcfrx_checker u_chk (.*);

`default_nettype wire
